// ===== hdl/gfrm_pkg.sv =====
// ----------------------------------------------------------------------------
// gfrm_pkg
// Types, codes and the GF(2^16) multiply used by the region MAC / butterfly
// block. Field polynomial is x^16+x^5+x^3+x^2+1.
// ----------------------------------------------------------------------------
`default_nettype none

package gfrm_pkg;

    localparam int unsigned SYM_W   = 16;
    localparam int unsigned MODE_W  = 3;
    localparam int unsigned CFG_IDX_W = 2;

    // op_mode codes
    localparam logic [MODE_W-1:0] MODE_MUL     = 3'd0;
    localparam logic [MODE_W-1:0] MODE_MAC     = 3'd1;
    localparam logic [MODE_W-1:0] MODE_DUAL    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_FWD_BFY = 3'd3;
    localparam logic [MODE_W-1:0] MODE_INV_BFY = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_COEF  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF2 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 2'd2;

    typedef logic [SYM_W-1:0] t_sym;

    typedef struct packed {
        t_sym operand_a;
        t_sym operand_b;
        t_sym operand_c;
        logic last_in;
    } t_in_item;

    typedef struct packed {
        t_sym result_a;
        t_sym result_b;
        logic last_out;
    } t_out_item;

    // GF(2^16) product: carry-less 16x16 multiply, then two folds of the
    // bits above bit 15 by 0x2D (x^5+x^3+x^2+1).
    function automatic t_sym gf_mul(input t_sym x, input t_sym y);
        logic [2*SYM_W-2:0] prod;
        logic [20:0]        fold1;
        logic [15:0]        fold2;
        logic [14:0]        hi1;
        logic [4:0]         hi2;
        prod = '0;
        for (int i = 0; i < SYM_W; i++) begin
            if (y[i]) begin
                prod = prod ^ ({15'd0, x} << i);
            end
        end
        hi1   = prod[30:16];
        fold1 = {5'd0, prod[15:0]}
              ^ {6'd0, hi1} ^ {4'd0, hi1, 2'd0} ^ {3'd0, hi1, 3'd0} ^ {1'd0, hi1, 5'd0};
        hi2   = fold1[20:16];
        fold2 = fold1[15:0]
              ^ {11'd0, hi2} ^ {9'd0, hi2, 2'd0} ^ {8'd0, hi2, 3'd0} ^ {6'd0, hi2, 5'd0};
        return fold2;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/gf16_region_mac_butterfly.sv =====
// ----------------------------------------------------------------------------
// gf16_region_mac_butterfly
// GF(2^16) region multiply, multiply-accumulate, dual MAC and additive-FFT
// butterflies, one symbol position per transaction.
// ----------------------------------------------------------------------------
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+-----------------------------
//   in      | input     | i_in_valid / o_in_stall | i_in_data  (t_in_item)
//   out     | output    | o_out_valid / i_out_stall | o_out_data (t_out_item)
//   cfg     | input     | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// One transaction per cycle sustained while i_out_stall is low; the input
// register feeds the GF multipliers, which feed the result register.
// Reset (synchronous, active low) empties both registers and clears the
// configuration to zero. A stall at the output holds the result register and,
// once the input register is also full, raises o_in_stall.
// ----------------------------------------------------------------------------
`default_nettype none

module gf16_region_mac_butterfly (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_in_valid,
    output logic                       o_in_stall,
    input  gfrm_pkg::t_in_item         i_in_data,
    output logic                       o_out_valid,
    input  wire                        i_out_stall,
    output gfrm_pkg::t_out_item        o_out_data,
    input  wire                        i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire [gfrm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire [gfrm_pkg::SYM_W-1:0]  i_cfg_data
);
    import gfrm_pkg::*;

    logic              r_in_valid;
    t_in_item          r_in;
    logic              r_out_valid;
    t_out_item         r_out;
    t_sym              r_coef;
    t_sym              r_coef2;
    logic [MODE_W-1:0] r_mode;

    logic      out_adv;
    logic      in_load;
    t_sym      mul1_op;
    t_sym      mul1_res;
    t_sym      mul2_res;
    t_out_item n_out;

    // Configuration registers, always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef  <= '0;
            r_coef2 <= '0;
            r_mode  <= MODE_MUL;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_COEF:  r_coef  <= i_cfg_data;
                CFG_COEF2: r_coef2 <= i_cfg_data;
                CFG_MODE:  r_mode  <= i_cfg_data[MODE_W-1:0];
                default:   ;
            endcase
        end
    end

    // Flow control: result register moves when empty or not stalled
    assign out_adv    = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_in_valid && !out_adv;
    assign in_load    = i_in_valid && !o_in_stall;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_load) begin
            r_in <= i_in_data;
        end
    end

    // Multiplier operand: source symbol, y, or y^x per mode
    always_comb begin
        case (r_mode)
            MODE_FWD_BFY: mul1_op = r_in.operand_b;
            MODE_INV_BFY: mul1_op = r_in.operand_b ^ r_in.operand_a;
            default:      mul1_op = r_in.operand_a;
        endcase
    end

    assign mul1_res = gf_mul(mul1_op, r_coef);
    assign mul2_res = gf_mul(r_in.operand_a, r_coef2);

    // Result selection
    always_comb begin
        n_out.result_a = '0;
        n_out.result_b = '0;
        n_out.last_out = r_in.last_in;
        case (r_mode)
            MODE_MUL: begin
                n_out.result_a = mul1_res;
            end
            MODE_MAC: begin
                n_out.result_a = r_in.operand_b ^ mul1_res;
            end
            MODE_DUAL: begin
                n_out.result_a = r_in.operand_b ^ mul1_res;
                n_out.result_b = r_in.operand_c ^ mul2_res;
            end
            MODE_FWD_BFY: begin
                n_out.result_a = r_in.operand_a ^ mul1_res;
                n_out.result_b = r_in.operand_b ^ r_in.operand_a ^ mul1_res;
            end
            MODE_INV_BFY: begin
                n_out.result_a = r_in.operand_a ^ mul1_res;
                n_out.result_b = mul1_op;
            end
            default: ;
        endcase
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_adv) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_adv && r_in_valid) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Checks
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid && i_out_stall))
        else $error("input stalled while a register is free");

    a_last_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && out_adv) |=> (o_out_valid && o_out_data.last_out == $past(r_in.last_in)))
        else $error("result register missed a transaction or lost its last flag");

endmodule

`default_nettype wire
